### src/hist2d_pkg.sv
// shared types, codes and the density glyph table of the 2d histogram binner
// depends on nothing; the top level, hist2d_cfg_regs and hist2d_axis_map use it by scoped names
package hist2d_pkg;

    // input word command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_CELLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_CELLS = 3'd5;

    // register reset values
    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
    localparam logic [6:0]  CELLS_RESET = 7'd64;

    // largest index into the glyph table
    localparam int unsigned GLYPH_LAST = 31;

    // configuration register file contents
    typedef struct packed {
        logic signed [31:0] x_low_bound;
        logic signed [31:0] y_low_bound;
        logic [31:0]        x_scale;
        logic [31:0]        y_scale;
        logic [6:0]         x_cells;
        logic [6:0]         y_cells;
    } cfg_t;

    // axis mapper result: below the bound, and integer part of the product
    typedef struct packed {
        logic        neg;
        logic [31:0] hi;
    } map_t;

    // density glyph for a saturated count index
    function automatic logic [7:0] glyph_of(input logic [4:0] idx);
        logic [7:0] g;
        case (idx) inside
            5'd0:          g = 8'h2E;                 // '.'
            [5'd1:5'd9]:   g = 8'h30 + {3'b000, idx}; // '1'..'9'
            5'd10:         g = 8'h30;                 // '0'
            [5'd11:5'd15]: g = 8'h24;                 // '$'
            [5'd16:5'd20]: g = 8'h23;                 // '#'
            [5'd21:5'd25]: g = 8'h25;                 // '%'
            [5'd26:5'd30]: g = 8'h40;                 // '@'
            default:       g = 8'h3E;                 // '>'
        endcase
        return g;
    endfunction

endpackage

### src/two_d_histogram_binner.sv
// top level of the 2d histogram binner: sequencer, statistics, output word
// depends on hist2d_pkg, hist2d_cfg_regs, hist2d_axis_map, hist2d_count_ram
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  cmd x_value y_value read_x read_y
//  out      output     out_valid/out_stall  in_range cell_count glyph_code
//                                           total_pairs missed_pairs covered_cells
//  cfg      input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// an add word steps through accept, x and y in the shared two-stage axis mapper with y
// entering the cycle after x, address forming and the memory read-modify-write
// a read word steps through accept, address and read-modify-write
// after reset a clearing pass writes zero to all MAX_X_CELLS*MAX_Y_CELLS entries, one per
// cycle, with in_stall high
// a finished word waits in the output register while out_stall is high;
// the memory update and statistics are committed only when it is loaded
module two_d_histogram_binner #(
    parameter int unsigned MAX_X_CELLS = 64,
    parameter int unsigned MAX_Y_CELLS = 64,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic signed [31:0]               x_value,
    input  logic signed [31:0]               y_value,
    input  logic [5:0]                       read_x,
    input  logic [5:0]                       read_y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             in_range,
    output logic [15:0]                      cell_count,
    output logic [7:0]                       glyph_code,
    output logic [31:0]                      total_pairs,
    output logic [31:0]                      missed_pairs,
    output logic [12:0]                      covered_cells,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hist2d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int unsigned DEPTH  = MAX_X_CELLS * MAX_Y_CELLS;
    localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XI_W   = (MAX_X_CELLS > 1) ? $clog2(MAX_X_CELLS) : 1;
    localparam int unsigned YI_W   = (MAX_Y_CELLS > 1) ? $clog2(MAX_Y_CELLS) : 1;
    localparam int unsigned XC_W   = $clog2(MAX_X_CELLS + 1);
    localparam int unsigned YC_W   = $clog2(MAX_Y_CELLS + 1);
    localparam int unsigned COV_RW = $clog2(DEPTH + 1);
    localparam int unsigned COV_W  = (COV_RW > 13) ? COV_RW : 13;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_TAKE_X,
        ST_ADDR,
        ST_RMW
    } state_t;

    hist2d_pkg::cfg_t cfg;
    hist2d_pkg::map_t map_res;

    logic [31:0] map_value;
    logic [31:0] map_low;
    logic [31:0] map_scale;

    logic [XC_W-1:0] cx;
    logic [YC_W-1:0] cy;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               cmd_reg, cmd_next;
    logic [31:0]        xv_reg, xv_next;
    logic [31:0]        yv_reg, yv_next;
    logic [5:0]         rx_reg, rx_next;
    logic [5:0]         ry_reg, ry_next;
    logic               xhit_reg, xhit_next;
    logic [XI_W-1:0]    xidx_reg, xidx_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [31:0]        total_reg, total_next;
    logic [31:0]        missed_reg, missed_next;
    logic [COV_W-1:0]   cov_reg, cov_next;
    logic               ovalid_reg, ovalid_next;
    logic               orange_reg, orange_next;
    logic [15:0]        ocount_reg, ocount_next;
    logic [7:0]         oglyph_reg, oglyph_next;

    logic [XI_W-1:0]        ix;
    logic [YI_W-1:0]        iy;
    logic                   hit_now;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] res_cnt;
    logic [31:0]            res_cnt32;
    logic [4:0]             glyph_idx;
    logic                   out_free;
    logic                   commit;

    hist2d_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hist2d_axis_map u_map (
        .clk       (clk),
        .value     (map_value),
        .low_bound (map_low),
        .scale     (map_scale),
        .result    (map_res)
    );

    hist2d_count_ram #(
        .DEPTH (DEPTH),
        .WIDTH (COUNT_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;

    // cell counts in use, capped at the store size
    assign cx = (32'(cfg.x_cells) > 32'(MAX_X_CELLS)) ? XC_W'(MAX_X_CELLS)
                                                      : XC_W'(cfg.x_cells);
    assign cy = (32'(cfg.y_cells) > 32'(MAX_Y_CELLS)) ? YC_W'(MAX_Y_CELLS)
                                                      : YC_W'(cfg.y_cells);

    // shared mapper takes x in its first cycle and y in the next
    assign map_value = (state_reg == ST_MAP_X) ? xv_reg : yv_reg;
    assign map_low   = (state_reg == ST_MAP_X) ? cfg.x_low_bound : cfg.y_low_bound;
    assign map_scale = (state_reg == ST_MAP_X) ? cfg.x_scale : cfg.y_scale;

    // cell lookup: axis indexes and whether the word hits a cell
    always_comb
    begin
        if (cmd_reg == hist2d_pkg::CMD_ADD)
        begin
            ix      = xidx_reg;
            iy      = YI_W'(map_res.hi);
            hit_now = xhit_reg && !map_res.neg && (map_res.hi < 32'(cy));
        end
        else
        begin
            ix      = XI_W'(rx_reg);
            iy      = YI_W'(ry_reg);
            hit_now = (32'(rx_reg) < 32'(cx)) && (32'(ry_reg) < 32'(cy));
        end
    end

    // count update and result word
    assign cnt_inc   = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata
                                                          : ram_rdata + 1'b1;
    assign res_cnt   = !hit_reg ? '0 :
                       (cmd_reg == hist2d_pkg::CMD_ADD) ? cnt_inc : ram_rdata;
    assign res_cnt32 = 32'(res_cnt);
    assign glyph_idx = (res_cnt > COUNT_WIDTH'(hist2d_pkg::GLYPH_LAST))
                       ? 5'(hist2d_pkg::GLYPH_LAST) : res_cnt[4:0];
    assign out_free  = !ovalid_reg || !out_stall;
    assign commit    = (state_reg == ST_RMW) && out_free;

    // memory write: clearing pass or committed add
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = cnt_inc;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (commit && hit_reg && (cmd_reg == hist2d_pkg::CMD_ADD))
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = (state_reg == ST_ADDR);

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        xv_next     = xv_reg;
        yv_next     = yv_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        xhit_next   = xhit_reg;
        xidx_next   = xidx_reg;
        hit_next    = hit_reg;
        addr_next   = addr_reg;
        total_next  = total_reg;
        missed_next = missed_reg;
        cov_next    = cov_reg;
        ovalid_next = ovalid_reg && out_stall;
        orange_next = orange_reg;
        ocount_next = ocount_reg;
        oglyph_next = oglyph_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    xv_next    = x_value;
                    yv_next    = y_value;
                    rx_next    = read_x;
                    ry_next    = read_y;
                    state_next = (cmd == hist2d_pkg::CMD_ADD) ? ST_MAP_X : ST_ADDR;
                end
            end
            ST_MAP_X:
            begin
                state_next = ST_MAP_Y;
            end
            ST_MAP_Y:
            begin
                state_next = ST_TAKE_X;
            end
            ST_TAKE_X:
            begin
                xhit_next  = !map_res.neg && (map_res.hi < 32'(cx));
                xidx_next  = XI_W'(map_res.hi);
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                hit_next   = hit_now;
                addr_next  = AW'(ix) * AW'(MAX_Y_CELLS) + AW'(iy);
                state_next = ST_RMW;
            end
            ST_RMW:
            begin
                if (out_free)
                begin
                    if (cmd_reg == hist2d_pkg::CMD_ADD)
                    begin
                        total_next = (total_reg == '1) ? total_reg : total_reg + 1'b1;
                        if (!hit_reg)
                        begin
                            missed_next = (missed_reg == '1) ? missed_reg
                                                             : missed_reg + 1'b1;
                        end
                        else if (ram_rdata == '0)
                        begin
                            cov_next = cov_reg + 1'b1;
                        end
                    end
                    ovalid_next = 1'b1;
                    orange_next = hit_reg;
                    ocount_next = res_cnt32[15:0];
                    oglyph_next = hit_reg ? hist2d_pkg::glyph_of(glyph_idx) : 8'd0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            total_reg  <= '0;
            missed_reg <= '0;
            cov_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            total_reg  <= total_next;
            missed_reg <= missed_next;
            cov_reg    <= cov_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // word payload and working registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        xv_reg     <= xv_next;
        yv_reg     <= yv_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        xhit_reg   <= xhit_next;
        xidx_reg   <= xidx_next;
        hit_reg    <= hit_next;
        addr_reg   <= addr_next;
        orange_reg <= orange_next;
        ocount_reg <= ocount_next;
        oglyph_reg <= oglyph_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = ovalid_reg;
    assign in_range      = orange_reg;
    assign cell_count    = ocount_reg;
    assign glyph_code    = oglyph_reg;
    assign total_pairs   = total_reg;
    assign missed_pairs  = missed_reg;
    assign covered_cells = cov_reg[12:0];

endmodule

### src/hist2d_cfg_regs.sv
// configuration register file of the 2d histogram binner
// depends on hist2d_pkg (cfg_t, register indexes, reset values)
module hist2d_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [hist2d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output hist2d_pkg::cfg_t               cfg
);

    hist2d_pkg::cfg_t cfg_reg;

    // register writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_low_bound <= '0;
            cfg_reg.y_low_bound <= '0;
            cfg_reg.x_scale     <= hist2d_pkg::SCALE_RESET;
            cfg_reg.y_scale     <= hist2d_pkg::SCALE_RESET;
            cfg_reg.x_cells     <= hist2d_pkg::CELLS_RESET;
            cfg_reg.y_cells     <= hist2d_pkg::CELLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hist2d_pkg::CFG_X_LOW:   cfg_reg.x_low_bound <= cfg_data;
                hist2d_pkg::CFG_Y_LOW:   cfg_reg.y_low_bound <= cfg_data;
                hist2d_pkg::CFG_X_SCALE: cfg_reg.x_scale     <= cfg_data;
                hist2d_pkg::CFG_Y_SCALE: cfg_reg.y_scale     <= cfg_data;
                hist2d_pkg::CFG_X_CELLS: cfg_reg.x_cells     <= cfg_data[6:0];
                hist2d_pkg::CFG_Y_CELLS: cfg_reg.y_cells     <= cfg_data[6:0];
                default:                 ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/hist2d_axis_map.sv
// axis mapper: offset from the low bound, then times cells per unit
// two register stages; depends on hist2d_pkg (map_t)
module hist2d_axis_map (
    input  logic              clk,
    input  logic [31:0]       value,
    input  logic [31:0]       low_bound,
    input  logic [31:0]       scale,
    output hist2d_pkg::map_t  result
);

    logic [32:0] diff;
    logic [31:0] diff_reg;
    logic        neg1_reg;
    logic [31:0] scale_reg;
    logic [63:0] prod;
    logic [31:0] hi_reg;
    logic        neg2_reg;

    // exact 33-bit signed difference; a nonnegative one fits in 32 bits
    assign diff = {value[31], value} - {low_bound[31], low_bound};

    // q16.16 times q16.16 gives q32.32, keep the integer part
    assign prod = {32'd0, diff_reg} * {32'd0, scale_reg};

    // offset stage then product stage
    always_ff @(posedge clk)
    begin
        diff_reg  <= diff[31:0];
        neg1_reg  <= diff[32];
        scale_reg <= scale;
        hi_reg    <= prod[63:32];
        neg2_reg  <= neg1_reg;
    end

    assign result.neg = neg2_reg;
    assign result.hi  = hi_reg;

endmodule

### src/hist2d_count_ram.sv
// single-port-write, single-port-read count memory with registered read data
// depends on nothing
module hist2d_count_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/hist2d_checker.sv
// port-level checks of the 2d histogram binner and the bind that attaches them
// depends on two_d_histogram_binner's port list
module hist2d_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        in_range,
    input  logic [15:0] cell_count,
    input  logic [7:0]  glyph_code,
    input  logic [31:0] total_pairs,
    input  logic [31:0] missed_pairs,
    input  logic [12:0] covered_cells
);

    // one word at a time: an accepted word stalls the input next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input word accepted while previous word in flight");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(in_range)
            && $stable(cell_count) && $stable(glyph_code) && $stable(total_pairs)
            && $stable(missed_pairs) && $stable(covered_cells))
        else $error("result word changed under stall");

    // a miss or invalid read reports no count and no glyph
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> cell_count == 16'd0 && glyph_code == 8'd0)
        else $error("missed word carries count or glyph");

    // missed pairs never exceed pairs added
    a_missed_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> missed_pairs <= total_pairs)
        else $error("missed pairs above total pairs");

    // every covered cell came from an added pair
    a_cov_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {19'd0, covered_cells} <= total_pairs)
        else $error("covered cells above total pairs");

endmodule

bind two_d_histogram_binner hist2d_checker u_hist2d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .in_range      (in_range),
    .cell_count    (cell_count),
    .glyph_code    (glyph_code),
    .total_pairs   (total_pairs),
    .missed_pairs  (missed_pairs),
    .covered_cells (covered_cells)
);
